// ===== rtl/core/sr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sr_pkg
// Shared constants, types and arithmetic helpers for the Schroeder reverb.
// ----------------------------------------------------------------------------
package sr_pkg;

    localparam int N_COMBS     = 8;
    localparam int N_ALLPASS   = 4;
    localparam int MAX_DELAY   = 2048;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;

    localparam int N_FILT    = N_COMBS + N_ALLPASS;
    localparam int FILT_W    = (N_FILT > 1) ? $clog2(N_FILT) : 1;
    localparam int CIDX_W    = (N_COMBS > 1) ? $clog2(N_COMBS) : 1;
    localparam int PTR_W     = $clog2(MAX_DELAY);
    localparam int LEN_W     = $clog2(MAX_DELAY + 1);
    localparam int MEM_DEPTH = N_FILT * MAX_DELAY;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 4;
    localparam int LFIELD_W  = 16;

    localparam int MUL_A_W = SAMPLE_BITS + 2;
    localparam int MUL_B_W = COEF_BITS + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W   = PROD_W - COEF_BITS;
    localparam int SAT_W   = RND_W + 2;
    localparam int SUM_W   = SAMPLE_BITS + CIDX_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMB_LEN_LO = 4'd0,
        REG_COMB_LEN_HI = 4'd1,
        REG_AP_LEN      = 4'd2,
        REG_FB_GAIN     = 4'd3,
        REG_DAMP        = 4'd4,
        REG_AP_GAIN     = 4'd5,
        REG_DRY_GAIN    = 4'd6,
        REG_WET_GAIN    = 4'd7
    } sr_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0]     comb_len_lo;
        logic [CFG_W-1:0]     comb_len_hi;
        logic [CFG_W-1:0]     ap_len;
        logic [COEF_BITS-1:0] fb_gain;
        logic [COEF_BITS-1:0] damp;
        logic [COEF_BITS-1:0] ap_gain;
        logic [COEF_BITS-1:0] dry_gain;
        logic [COEF_BITS-1:0] wet_gain;
    } sr_cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_READ,
        OP_C_MULD,
        OP_C_DAMP,
        OP_C_MULG,
        OP_C_WRITE,
        OP_A_MUL,
        OP_A_WRITE,
        OP_A_UPD,
        OP_MIX_DRY,
        OP_MIX_WET,
        OP_OUT
    } sr_op_t;

    typedef struct packed {
        logic clear_last;
        logic is_comb;
        logic last_filt;
        logic out_full;
    } sr_stat_t;

    // clamp to the signed sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        lo = {{(SAT_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
        if (v > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (v < lo)
            return lo[SAMPLE_BITS-1:0];
        else
            return v[SAMPLE_BITS-1:0];
    endfunction

    // round half up, then floor shift by the coefficient width
    function automatic logic signed [RND_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + $signed({{(PROD_W-COEF_BITS){1'b0}}, 1'b1, {(COEF_BITS-1){1'b0}}});
        return t[PROD_W-1:COEF_BITS];
    endfunction

    // effective delay length of filter f; zero or oversize means full length
    function automatic logic [LEN_W-1:0] filt_len(input sr_cfg_t cfg,
                                                  input logic [FILT_W-1:0] f);
        logic [CFG_W-1:0]    r;
        logic [1:0]          k;
        logic [LFIELD_W-1:0] fld;
        if (f < FILT_W'(N_COMBS)) begin
            r = (f < FILT_W'(4)) ? cfg.comb_len_lo : cfg.comb_len_hi;
            k = f[1:0];
        end else begin
            r = cfg.ap_len;
            k = 2'(f - FILT_W'(N_COMBS));
        end
        fld = r[LFIELD_W*k +: LFIELD_W];
        if (fld == '0 || 32'(fld) > MAX_DELAY)
            return LEN_W'(MAX_DELAY);
        else
            return fld[LEN_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/schroeder_reverb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// schroeder_reverb
// Mono in, stereo out reverb: eight damped feedback combs, four allpasses.
//
// Input channel: in_valid / in_stall with dry_sample (signed Q1.23). A beat
// is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with left_sample and right_sample.
// Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
// Indexes above seven are ignored.
// Every filter step of a beat uses the single shared multiplier and the
// one-port delay memory in turn, and a new beat is taken only when the
// last one has left its output step. One beat is in work at a time.
// out_valid is set by that output step, after the walk over all filters.
// After reset the delay memory is cleared one entry per cycle
// (N_FILT*MAX_DELAY = 24576 entries); in_stall stays high until then.
// A result waits in the output register while out_stall is high; the next
// beat is still accepted and computed, and holds in its last step until the
// output register frees up.
// ----------------------------------------------------------------------------
module schroeder_reverb (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [sr_pkg::SAMPLE_BITS-1:0] dry_sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [sr_pkg::SAMPLE_BITS-1:0]      left_sample,
    output logic signed [sr_pkg::SAMPLE_BITS-1:0]      right_sample,
    input  wire logic                                  cfg_write,
    input  wire logic [sr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [sr_pkg::CFG_W-1:0]              cfg_data
);

    sr_pkg::sr_cfg_t  cfg_reg;
    sr_pkg::sr_op_t   op;
    sr_pkg::sr_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.comb_len_lo <= '0;
            cfg_reg.comb_len_hi <= '0;
            cfg_reg.ap_len      <= '0;
            cfg_reg.fb_gain     <= '0;
            cfg_reg.damp        <= '0;
            cfg_reg.ap_gain     <= sr_pkg::COEF_BITS'(32768);
            cfg_reg.dry_gain    <= sr_pkg::COEF_BITS'(65535);
            cfg_reg.wet_gain    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (sr_pkg::sr_reg_t'(cfg_index))
                sr_pkg::REG_COMB_LEN_LO: cfg_reg.comb_len_lo <= cfg_data;
                sr_pkg::REG_COMB_LEN_HI: cfg_reg.comb_len_hi <= cfg_data;
                sr_pkg::REG_AP_LEN:      cfg_reg.ap_len      <= cfg_data;
                sr_pkg::REG_FB_GAIN:     cfg_reg.fb_gain     <= cfg_data[sr_pkg::COEF_BITS-1:0];
                sr_pkg::REG_DAMP:        cfg_reg.damp        <= cfg_data[sr_pkg::COEF_BITS-1:0];
                sr_pkg::REG_AP_GAIN:     cfg_reg.ap_gain     <= cfg_data[sr_pkg::COEF_BITS-1:0];
                sr_pkg::REG_DRY_GAIN:    cfg_reg.dry_gain    <= cfg_data[sr_pkg::COEF_BITS-1:0];
                sr_pkg::REG_WET_GAIN:    cfg_reg.wet_gain    <= cfg_data[sr_pkg::COEF_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .op       (op)
    );

    sr_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .cfg          (cfg_reg),
        .dry_sample   (dry_sample),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .stat         (stat)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sr_ctrl
// Sequencer: clearing pass, then per-beat walk over combs, allpasses, mix.
// ----------------------------------------------------------------------------
module sr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire sr_pkg::sr_stat_t stat,
    output sr_pkg::sr_op_t        op
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_C_MULD,
        S_C_DAMP,
        S_C_MULG,
        S_C_WRITE,
        S_A_MUL,
        S_A_WRITE,
        S_A_UPD,
        S_MIX_DRY,
        S_MIX_WET,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = sr_pkg::OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = sr_pkg::OP_CLEAR;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = sr_pkg::OP_LOAD;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                op         = sr_pkg::OP_READ;
                state_next = stat.is_comb ? S_C_MULD : S_A_MUL;
            end
            S_C_MULD:
            begin
                op         = sr_pkg::OP_C_MULD;
                state_next = S_C_DAMP;
            end
            S_C_DAMP:
            begin
                op         = sr_pkg::OP_C_DAMP;
                state_next = S_C_MULG;
            end
            S_C_MULG:
            begin
                op         = sr_pkg::OP_C_MULG;
                state_next = S_C_WRITE;
            end
            S_C_WRITE:
            begin
                op         = sr_pkg::OP_C_WRITE;
                state_next = S_READ;
            end
            S_A_MUL:
            begin
                op         = sr_pkg::OP_A_MUL;
                state_next = S_A_WRITE;
            end
            S_A_WRITE:
            begin
                op         = sr_pkg::OP_A_WRITE;
                state_next = S_A_UPD;
            end
            S_A_UPD:
            begin
                op         = sr_pkg::OP_A_UPD;
                state_next = stat.last_filt ? S_MIX_DRY : S_READ;
            end
            S_MIX_DRY:
            begin
                op         = sr_pkg::OP_MIX_DRY;
                state_next = S_MIX_WET;
            end
            S_MIX_WET:
            begin
                op         = sr_pkg::OP_MIX_WET;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register can take the result
                if (!stat.out_full)
                begin
                    op         = sr_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sr_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sr_dpath
// Delay memory, pointers, damping state, shared multiplier, output register.
// ----------------------------------------------------------------------------
module sr_dpath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire sr_pkg::sr_op_t                        op,
    input  wire sr_pkg::sr_cfg_t                       cfg,
    input  wire logic signed [sr_pkg::SAMPLE_BITS-1:0] dry_sample,
    input  wire logic                                  out_stall,
    output logic                                       out_valid,
    output logic signed [sr_pkg::SAMPLE_BITS-1:0]      left_sample,
    output logic signed [sr_pkg::SAMPLE_BITS-1:0]      right_sample,
    output sr_pkg::sr_stat_t                           stat
);

    localparam int SW = sr_pkg::SAMPLE_BITS;

    logic signed [SW-1:0] mem [sr_pkg::MEM_DEPTH];

    logic [sr_pkg::FILT_W-1:0] f_reg;
    logic [sr_pkg::PTR_W-1:0]  ptr_reg [sr_pkg::N_FILT];
    logic signed [SW-1:0]      dmem_reg [sr_pkg::N_COMBS];
    logic [sr_pkg::ADDR_W-1:0] clr_reg;
    logic                      out_valid_reg;

    logic signed [SW-1:0]                 rdata_reg;
    logic signed [SW-1:0]                 x_reg;
    logic signed [sr_pkg::SUM_W-1:0]      sum_reg;
    logic signed [SW-1:0]                 v_reg;
    logic signed [SW-1:0]                 m_reg;
    logic signed [sr_pkg::PROD_W-1:0]     prod_reg;
    logic signed [sr_pkg::RND_W-1:0]      dry_reg;
    logic signed [SW-1:0]                 left_reg;
    logic signed [SW-1:0]                 right_reg;

    logic [sr_pkg::PTR_W-1:0]          cur_ptr;
    logic [sr_pkg::LEN_W-1:0]          ptr_inc;
    logic [sr_pkg::PTR_W-1:0]          ptr_adv;
    logic [sr_pkg::ADDR_W-1:0]         addr;
    logic signed [SW-1:0]              dmem_cur;
    logic signed [sr_pkg::MUL_A_W-1:0] mul_a;
    logic [sr_pkg::COEF_BITS-1:0]      coef;
    logic signed [sr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [sr_pkg::RND_W-1:0]   rnd;
    logic signed [SW-1:0]              damp_m;
    logic signed [SW-1:0]              wr_comb;
    logic signed [SW-1:0]              wr_ap;
    logic signed [SW-1:0]              v_upd;
    logic                              wr_en;
    logic [sr_pkg::ADDR_W-1:0]         wr_addr;
    logic signed [SW-1:0]              wr_data;
    logic                              advance;

    assign cur_ptr  = ptr_reg[f_reg];
    assign dmem_cur = dmem_reg[f_reg[sr_pkg::CIDX_W-1:0]];
    assign addr     = sr_pkg::ADDR_W'(f_reg) * sr_pkg::ADDR_W'(sr_pkg::MAX_DELAY)
                    + sr_pkg::ADDR_W'(cur_ptr);

    // pointer wraps when it reaches the length, also after a shortened length
    assign ptr_inc = sr_pkg::LEN_W'(cur_ptr) + sr_pkg::LEN_W'(1);
    assign ptr_adv = (ptr_inc >= sr_pkg::filt_len(cfg, f_reg)) ? '0
                                                                 : ptr_inc[sr_pkg::PTR_W-1:0];

    always_comb
    begin
        mul_a = '0;
        coef  = '0;
        unique case (op)
            sr_pkg::OP_C_MULD:
            begin
                mul_a = sr_pkg::MUL_A_W'(dmem_cur) - sr_pkg::MUL_A_W'(rdata_reg);
                coef  = cfg.damp;
            end
            sr_pkg::OP_C_MULG:
            begin
                mul_a = sr_pkg::MUL_A_W'(m_reg);
                coef  = cfg.fb_gain;
            end
            sr_pkg::OP_A_MUL:
            begin
                mul_a = sr_pkg::MUL_A_W'(rdata_reg);
                coef  = cfg.ap_gain;
            end
            sr_pkg::OP_A_WRITE:
            begin
                mul_a = sr_pkg::MUL_A_W'(v_reg);
                coef  = cfg.ap_gain;
            end
            sr_pkg::OP_MIX_DRY:
            begin
                mul_a = sr_pkg::MUL_A_W'(x_reg);
                coef  = cfg.dry_gain;
            end
            sr_pkg::OP_MIX_WET:
            begin
                mul_a = sr_pkg::MUL_A_W'(v_reg);
                coef  = cfg.wet_gain;
            end
            default:
            begin
                mul_a = '0;
                coef  = '0;
            end
        endcase
    end

    assign mul_b = $signed({1'b0, coef});
    assign rnd   = sr_pkg::rnd_q(prod_reg);

    assign damp_m  = sr_pkg::sat_s(sr_pkg::SAT_W'(rdata_reg) + sr_pkg::SAT_W'(rnd));
    assign wr_comb = sr_pkg::sat_s(sr_pkg::SAT_W'(rnd) + sr_pkg::SAT_W'(x_reg));
    assign wr_ap   = sr_pkg::sat_s(sr_pkg::SAT_W'(rnd) + sr_pkg::SAT_W'(v_reg));
    assign v_upd   = sr_pkg::sat_s(sr_pkg::SAT_W'(rdata_reg) - sr_pkg::SAT_W'(rnd));

    assign advance = (op == sr_pkg::OP_C_WRITE) || (op == sr_pkg::OP_A_UPD);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr;
        wr_data = '0;
        unique case (op)
            sr_pkg::OP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            sr_pkg::OP_C_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = wr_comb;
            end
            sr_pkg::OP_A_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = wr_ap;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (op == sr_pkg::OP_READ)
            rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg         <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sr_pkg::N_FILT; i++)
                ptr_reg[i] <= '0;
            for (int i = 0; i < sr_pkg::N_COMBS; i++)
                dmem_reg[i] <= '0;
        end
        else
        begin
            if (op == sr_pkg::OP_CLEAR)
                clr_reg <= clr_reg + sr_pkg::ADDR_W'(1);
            if (op == sr_pkg::OP_LOAD)
                f_reg <= '0;
            if (op == sr_pkg::OP_C_DAMP)
                dmem_reg[f_reg[sr_pkg::CIDX_W-1:0]] <= damp_m;
            if (advance)
            begin
                ptr_reg[f_reg] <= ptr_adv;
                if (!stat.last_filt)
                    f_reg <= f_reg + sr_pkg::FILT_W'(1);
            end
            if (op == sr_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // the wet product must survive while the result waits in S_OUT
        if (op != sr_pkg::OP_NONE)
            prod_reg <= mul_a * mul_b;
        unique case (op)
            sr_pkg::OP_LOAD:
            begin
                x_reg   <= dry_sample;
                sum_reg <= '0;
            end
            sr_pkg::OP_C_DAMP:
            begin
                m_reg   <= damp_m;
                sum_reg <= sum_reg + sr_pkg::SUM_W'(damp_m);
            end
            sr_pkg::OP_C_WRITE:
            begin
                // the last comb leaves the saturated sum as allpass input
                v_reg <= sr_pkg::sat_s(sr_pkg::SAT_W'(sum_reg));
            end
            sr_pkg::OP_A_UPD:
            begin
                v_reg <= v_upd;
            end
            sr_pkg::OP_MIX_WET:
            begin
                dry_reg <= rnd;
            end
            sr_pkg::OP_OUT:
            begin
                left_reg  <= sr_pkg::sat_s(sr_pkg::SAT_W'(dry_reg) + sr_pkg::SAT_W'(rnd));
                right_reg <= sr_pkg::sat_s(sr_pkg::SAT_W'(dry_reg) - sr_pkg::SAT_W'(rnd));
            end
            default:
            begin
            end
        endcase
    end

    assign stat.clear_last = (clr_reg == sr_pkg::ADDR_W'(sr_pkg::MEM_DEPTH - 1));
    assign stat.is_comb    = (f_reg < sr_pkg::FILT_W'(sr_pkg::N_COMBS));
    assign stat.last_filt  = (f_reg == sr_pkg::FILT_W'(sr_pkg::N_FILT - 1));
    assign stat.out_full   = out_valid_reg && out_stall;

    assign out_valid    = out_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;

    // a new result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sr_pkg::OP_OUT) |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    a_comb_index: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sr_pkg::OP_C_MULD || op == sr_pkg::OP_C_DAMP || op == sr_pkg::OP_C_WRITE)
        |-> (f_reg < sr_pkg::FILT_W'(sr_pkg::N_COMBS)))
        else $error("comb step on an allpass index");

    a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sr_pkg::OP_READ) |-> (f_reg < sr_pkg::FILT_W'(sr_pkg::N_FILT)))
        else $error("filter index out of range");

    a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sr_pkg::OP_OUT) |=> out_valid_reg)
        else $error("result not presented");

endmodule
`default_nettype wire

// ===== tb/tb_schroeder_reverb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_schroeder_reverb
// Self-checking bench for the Schroeder reverb. A directed table and then
// random samples are driven with random gaps and stalls. A bit-true
// predictor of the comb and allpass network computes each left and right
// beat. Register settings change between phases, only while the block is
// idle.
// ----------------------------------------------------------------------------
module tb_schroeder_reverb;

    localparam int SB        = sr_pkg::SAMPLE_BITS;
    localparam int N_RAND    = 1630;
    localparam int IDLE_LIM  = 100000;
    localparam int LAT       = 60;

    typedef logic signed [SB-1:0] samp_t;

    typedef struct packed {
        samp_t left;
        samp_t right;
    } stereo_t;

    typedef struct {
        samp_t   x;
        bit      known;
        stereo_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    samp_t       dry_sample;
    logic        out_valid;
    logic        out_stall;
    samp_t       left_sample;
    samp_t       right_sample;
    logic        cfg_write;
    logic [sr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sr_pkg::CFG_W-1:0]     cfg_data;

    schroeder_reverb dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dry_sample   (dry_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    longint delay_mem [sr_pkg::N_FILT*sr_pkg::MAX_DELAY];
    int     ptr       [sr_pkg::N_FILT];
    longint damp_mem  [sr_pkg::N_COMBS];
    logic [63:0] m_len_lo, m_len_hi, m_ap_len;
    longint m_fb, m_damp, m_apg, m_dry, m_wet;

    stereo_t expected_q[$];
    int      errors;
    int      idle_cycles = 0;
    bit      hold_off;
    int      n;
    int      out_gap;
    bit      out_took;
    row_t    dir_tab [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp(longint v);
        longint hi;
        hi = (longint'(1) << (SB - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // rounded Q0.16 product, floor shift
    function automatic longint qmul(longint a, longint c);
        longint p;
        p = a * (c & 65535) + (longint'(1) << (sr_pkg::COEF_BITS - 1));
        return p >>> sr_pkg::COEF_BITS;
    endfunction

    function automatic int tap_len(int f);
        logic [63:0] r;
        int len;
        if (f < sr_pkg::N_COMBS)
            r = (f < 4) ? m_len_lo : m_len_hi;
        else
            r = m_ap_len;
        len = int'(r[16*(f%4) +: 16]);
        if (len == 0 || len > sr_pkg::MAX_DELAY)
            len = sr_pkg::MAX_DELAY;
        return len;
    endfunction

    function automatic stereo_t reverb_step(samp_t xin);
        longint x, sum, v, tap, m, dry, wet;
        int idx;
        stereo_t r;
        x = longint'(xin);
        sum = 0;
        for (int f = 0; f < sr_pkg::N_FILT; f++)
        begin
            if (f == sr_pkg::N_COMBS)
                v = clamp(sum);
            idx = f * sr_pkg::MAX_DELAY + (ptr[f] % sr_pkg::MAX_DELAY);
            tap = delay_mem[idx];
            if (f < sr_pkg::N_COMBS)
            begin
                m = clamp(tap + qmul(damp_mem[f] - tap, m_damp));
                damp_mem[f] = m;
                delay_mem[idx] = clamp(qmul(m, m_fb) + x);
                sum += m;
            end
            else
            begin
                delay_mem[idx] = clamp(qmul(tap, m_apg) + v);
                v = clamp(tap - qmul(v, m_apg));
            end
            ptr[f] = (ptr[f] + 1 >= tap_len(f)) ? 0 : ptr[f] + 1;
        end
        dry = qmul(x, m_dry);
        wet = qmul(v, m_wet);
        r.left  = samp_t'(clamp(dry + wet));
        r.right = samp_t'(clamp(dry - wet));
        return r;
    endfunction

    task automatic write_reg(input int idx, input logic [63:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sr_pkg::CFG_IDX_W'(idx);
        cfg_data  <= val;
        case (idx)
            sr_pkg::REG_COMB_LEN_LO: m_len_lo = val;
            sr_pkg::REG_COMB_LEN_HI: m_len_hi = val;
            sr_pkg::REG_AP_LEN:      m_ap_len = val;
            sr_pkg::REG_FB_GAIN:     m_fb   = val[15:0];
            sr_pkg::REG_DAMP:        m_damp = val[15:0];
            sr_pkg::REG_AP_GAIN:     m_apg  = val[15:0];
            sr_pkg::REG_DRY_GAIN:    m_dry  = val[15:0];
            sr_pkg::REG_WET_GAIN:    m_wet  = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (LAT + 10) @(negedge clk);
    endtask

    // one beat on the input side, with a random gap first; called at a falling edge
    task automatic send(input samp_t x);
        int gap;
        gap = $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        dry_sample <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(reverb_step(x));
        @(negedge clk);
    endtask

    function automatic samp_t rand_sample();
        case ($urandom_range(0, 5))
            0: return samp_t'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
            1: return samp_t'($signed(10'($urandom())));
            default: return samp_t'($urandom());
        endcase
    endfunction

    function automatic logic [63:0] rand_lens();
        logic [63:0] r;
        for (int k = 0; k < 4; k++)
            case ($urandom_range(0, 5))
                0: r[16*k +: 16] = 16'd0;
                1: r[16*k +: 16] = 16'($urandom());
                2: r[16*k +: 16] = 16'd1;
                default: r[16*k +: 16] = 16'($urandom_range(2, 60));
            endcase
        return r;
    endfunction

    task automatic rand_config();
        write_reg(sr_pkg::REG_COMB_LEN_LO, rand_lens());
        write_reg(sr_pkg::REG_COMB_LEN_HI, rand_lens());
        write_reg(sr_pkg::REG_AP_LEN, rand_lens());
        write_reg(sr_pkg::REG_FB_GAIN, {$urandom(), $urandom()});
        write_reg(sr_pkg::REG_DAMP, 64'($urandom_range(0, 65535)));
        write_reg(sr_pkg::REG_AP_GAIN, 64'($urandom_range(0, 65535)));
        write_reg(sr_pkg::REG_DRY_GAIN, 64'($urandom_range(0, 65535)));
        write_reg(sr_pkg::REG_WET_GAIN, 64'($urandom_range(0, 65535)));
    endtask

    // output side: a random wait per beat, long hold-off on request
    always @(posedge clk)
        out_took <= out_valid && !out_stall;

    always @(negedge clk)
    begin
        if (out_took)
            out_gap = $urandom_range(0, 14);
        if (hold_off)
            out_stall <= 1'b1;
        else if (out_valid && out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap = out_gap - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // long hold-off while the sender keeps offering beats
    initial
    begin
        hold_off = 1'b0;
        wait (n >= 300);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: %0d %0d",
                           left_sample, right_sample);
                    errors++;
                end
                else
                begin
                    stereo_t e;
                    e = expected_q.pop_front();
                    if (left_sample !== e.left)
                    begin
                        $error("left_sample exp %0d got %0d", e.left, left_sample);
                        errors++;
                    end
                    if (right_sample !== e.right)
                    begin
                        $error("right_sample exp %0d got %0d", e.right, right_sample);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIM)
            begin
                $display("schroeder_reverb: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        stereo_t got;
        errors      = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        dry_sample  = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        foreach (delay_mem[i])
            delay_mem[i] = 0;
        foreach (ptr[i])
            ptr[i] = 0;
        foreach (damp_mem[i])
            damp_mem[i] = 0;
        m_len_lo = 0; m_len_hi = 0; m_ap_len = 0;
        m_fb = 0; m_damp = 0; m_apg = 32768; m_dry = 65535; m_wet = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // after reset, wet is off and dry is 65535/65536: read off directly
        dir_tab.push_back('{24'sh7fffff, 1'b1, {24'sh7fff7f, 24'sh7fff7f}});
        dir_tab.push_back('{24'sh800000, 1'b1, {24'sh800080, 24'sh800080}});
        dir_tab.push_back('{24'sh000000, 1'b1, {24'sh000000, 24'sh000000}});
        dir_tab.push_back('{24'sh000001, 1'b1, {24'sh000001, 24'sh000001}});
        dir_tab.push_back('{-24'sh1, 1'b1, {-24'sh1, -24'sh1}});
        foreach (dir_tab[i])
        begin
            got = reverb_step(dir_tab[i].x);
            if (dir_tab[i].known)
            begin
                if (got.left !== dir_tab[i].res.left)
                begin
                    $error("directed row %0d left_sample exp %0d got %0d", i,
                           dir_tab[i].res.left, got.left);
                    errors++;
                end
                if (got.right !== dir_tab[i].res.right)
                begin
                    $error("directed row %0d right_sample exp %0d got %0d", i,
                           dir_tab[i].res.right, got.right);
                    errors++;
                end
            end
        end
        // back to the reset state; send() steps the predictor again
        foreach (ptr[i])
            ptr[i] = 0;
        foreach (delay_mem[i])
            delay_mem[i] = 0;
        foreach (damp_mem[i])
            damp_mem[i] = 0;
        foreach (dir_tab[i])
            send(dir_tab[i].x);
        drain();

        // extremes: full gains, short and oversize lengths, saturating sum
        write_reg(sr_pkg::REG_COMB_LEN_LO, 64'h0001_0000_FFFF_0802);
        write_reg(sr_pkg::REG_COMB_LEN_HI, 64'h0003_0002_0001_0800);
        write_reg(sr_pkg::REG_AP_LEN, 64'h0000_0001_0005_FFFF);
        write_reg(sr_pkg::REG_FB_GAIN, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(sr_pkg::REG_DAMP, 64'h0);
        write_reg(sr_pkg::REG_AP_GAIN, 64'hFFFF);
        write_reg(sr_pkg::REG_DRY_GAIN, 64'hFFFF);
        write_reg(sr_pkg::REG_WET_GAIN, 64'hFFFF);
        write_reg(9, 64'h1234);
        write_reg(15, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send((i % 2) ? 24'sh800000 : 24'sh7fffff);
        drain();
        // shortened lengths: pointers past the new length wrap
        write_reg(sr_pkg::REG_COMB_LEN_LO, 64'h0002_0002_0002_0002);
        write_reg(sr_pkg::REG_DAMP, 64'hFFFF);
        write_reg(sr_pkg::REG_AP_GAIN, 64'h0);
        write_reg(sr_pkg::REG_DRY_GAIN, 64'h0);
        for (int i = 0; i < 6; i++)
            send(rand_sample());
        drain();

        // random phases
        n = 0;
        while (n < N_RAND)
        begin
            int phase_len;
            rand_config();
            phase_len = $urandom_range(40, 160);
            for (int i = 0; i < phase_len && n < N_RAND; i++, n++)
                send(rand_sample());
            drain();
        end

        if (errors == 0)
            $display("schroeder_reverb: match");
        else
            $display("schroeder_reverb: mismatch");
        $finish;
    end

endmodule
